// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the victim cache modules.
// ASSERT_RST expects signals named clk and rst_n in the calling scope, ASSERT_ALWAYS only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/vcls_pkg.sv =====
// Package for the victim cache: field widths, function codes and the
// command and status types between controller and datapath. No dependencies.
package vcls_pkg;

  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;
  localparam int OFF_W  = 4;

  localparam logic [OFF_W-1:0] OFF_RESET = 4'd5;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef struct packed {
    logic load;
    logic exec;
  } vcls_cmd_t;

  typedef struct packed {
    logic out_stall;
  } vcls_sts_t;

endpackage

// ===== rtl/vcls_in_if.sv =====
// Request channel of the victim cache: valid, ready and one request word.
// Depends on vcls_pkg for the field widths.
interface vcls_in_if import vcls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] swap_addr;
  logic              dirty;

  modport source (output valid, func, addr, swap_addr, dirty, input ready);
  modport sink   (input valid, func, addr, swap_addr, dirty, output ready);
endinterface

// ===== rtl/vcls_out_if.sv =====
// Result channel of the victim cache: valid, ready and one result word.
// Depends on vcls_pkg for the field widths.
interface vcls_out_if import vcls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [ADDR_W-1:0] hit_addr;
  logic              hit_dirty;
  logic              writeback;
  logic [ADDR_W-1:0] writeback_addr;
  logic [CNT_W-1:0]  swap_count;
  logic [CNT_W-1:0]  writeback_count;

  modport source (output valid, hit, hit_addr, hit_dirty, writeback, writeback_addr,
                  swap_count, writeback_count, input ready);
  modport sink   (input valid, hit, hit_addr, hit_dirty, writeback, writeback_addr,
                  swap_count, writeback_count, output ready);
endinterface

// ===== rtl/victim_cache_lru_swap.sv =====
// Fully associative victim cache with true LRU ages and swap on lookup hit.
// A request word is accepted in the idle state and its result word is registered by the
// update step that follows; no new request is accepted until that update is done.
// A stalled result word holds the update step, and no new request is accepted meanwhile.
// Synchronous active-low reset empties all entries and zeroes both totals.
// Depends on vcls_pkg, vcls_in_if, vcls_out_if, vcls_ctrl and vcls_dp.
module victim_cache_lru_swap import vcls_pkg::*; #(
  parameter int WAYS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  vcls_in_if.sink          in_ch,
  vcls_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [OFF_W-1:0] cfg_wdata
);

  vcls_cmd_t cmd;
  vcls_sts_t sts;

  vcls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vcls_dp #(
    .WAYS (WAYS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/vcls_ctrl.sv =====
// Controller of the victim cache: takes a request word, then runs one update.
// Depends on vcls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vcls_ctrl import vcls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  vcls_sts_t sts,
  output vcls_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_stall) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_RST(a_load_then_exec, cmd.load |=> state_r == S_EXEC, "load did not lead to exec")
  `ASSERT_RST(a_exec_not_stalled, cmd.exec |-> !sts.out_stall, "update while result stalled")

endmodule

// ===== rtl/vcls_dp.sv =====
// Datapath of the victim cache: entry store, tag match, LRU ages, totals and
// the result register. Depends on vcls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vcls_dp import vcls_pkg::*; #(
  parameter int WAYS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vcls_cmd_t          cmd,
  output vcls_sts_t          sts,
  input  logic               cfg_we,
  input  logic [OFF_W-1:0]   cfg_wdata,
  vcls_in_if.sink            in_ch,
  vcls_out_if.source         out_ch
);

  localparam int AW = $clog2(WAYS);
  localparam int IW = $clog2(WAYS);

  logic              func_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] saddr_r;
  logic              dirty_r;
  logic [OFF_W-1:0]  off_r;

  logic [ADDR_W-1:0] ent_addr_r  [WAYS];
  logic [ADDR_W-1:0] ent_addr_nxt[WAYS];
  logic [WAYS-1:0]   ent_valid_r, ent_valid_nxt;
  logic [WAYS-1:0]   ent_dirty_r, ent_dirty_nxt;
  logic [AW-1:0]     ent_age_r   [WAYS];
  logic [AW-1:0]     ent_age_nxt [WAYS];
  logic [CNT_W-1:0]  swap_tot_r, swap_tot_nxt;
  logic [CNT_W-1:0]  wb_tot_r, wb_tot_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              hit_r;
  logic [ADDR_W-1:0] hit_addr_r;
  logic              hit_dirty_r;
  logic              wb_r;
  logic [ADDR_W-1:0] wb_addr_r;

  logic [ADDR_W-1:0] tag_mask;
  logic [WAYS-1:0]   match;
  logic [IW-1:0]     hit_idx;
  logic              hit_any;
  logic [IW-1:0]     vic_idx;
  logic [AW-1:0]     hit_age;
  logic              res_hit;
  logic              res_wb;
  logic [WAYS-1:0]   age_seen;

  assign tag_mask = {ADDR_W{1'b1}} << off_r;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = ent_valid_r[i] && (((addr_r ^ ent_addr_r[i]) & tag_mask) == '0);
    end
  end

  always_comb begin
    hit_idx = '0;
    hit_any = 1'b0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IW'(i);
        hit_any = 1'b1;
      end
    end
    vic_idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (ent_age_r[i] == AW'(WAYS - 1)) begin
        vic_idx = IW'(i);
      end
    end
  end

  assign hit_age = ent_age_r[hit_idx];
  assign res_hit = (func_r == FUNC_LOOKUP) && hit_any;
  assign res_wb  = (func_r == FUNC_INSERT) && ent_dirty_r[vic_idx];

  always_comb begin
    ent_addr_nxt  = ent_addr_r;
    ent_valid_nxt = ent_valid_r;
    ent_dirty_nxt = ent_dirty_r;
    ent_age_nxt   = ent_age_r;
    swap_tot_nxt  = swap_tot_r;
    wb_tot_nxt    = wb_tot_r;
    if (func_r == FUNC_INSERT) begin
      for (int i = 0; i < WAYS; i++) begin
        ent_age_nxt[i] = ent_age_r[i] + AW'(1);
      end
      ent_age_nxt[vic_idx]   = '0;
      ent_addr_nxt[vic_idx]  = addr_r;
      ent_valid_nxt[vic_idx] = 1'b1;
      ent_dirty_nxt[vic_idx] = dirty_r;
      if (res_wb) begin
        wb_tot_nxt = wb_tot_r + CNT_W'(1);
      end
    end else if (hit_any) begin
      for (int i = 0; i < WAYS; i++) begin
        if (ent_age_r[i] < hit_age) begin
          ent_age_nxt[i] = ent_age_r[i] + AW'(1);
        end
      end
      ent_age_nxt[hit_idx]   = '0;
      ent_addr_nxt[hit_idx]  = saddr_r;
      ent_dirty_nxt[hit_idx] = dirty_r;
      swap_tot_nxt           = swap_tot_r + CNT_W'(1);
    end
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign sts.out_stall = out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_ch.func;
      addr_r  <= in_ch.addr;
      saddr_r <= in_ch.swap_addr;
      dirty_r <= in_ch.dirty;
    end
    if (cmd.exec) begin
      hit_r       <= res_hit;
      hit_addr_r  <= res_hit ? ent_addr_r[hit_idx] : '0;
      hit_dirty_r <= res_hit && ent_dirty_r[hit_idx];
      wb_r        <= res_wb;
      wb_addr_r   <= res_wb ? ent_addr_r[vic_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= OFF_RESET;
      ent_valid_r <= '0;
      ent_dirty_r <= '0;
      swap_tot_r  <= '0;
      wb_tot_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        ent_addr_r[i] <= '0;
        ent_age_r[i]  <= AW'(WAYS - 1 - i);
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        off_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        ent_addr_r  <= ent_addr_nxt;
        ent_valid_r <= ent_valid_nxt;
        ent_dirty_r <= ent_dirty_nxt;
        ent_age_r   <= ent_age_nxt;
        swap_tot_r  <= swap_tot_nxt;
        wb_tot_r    <= wb_tot_nxt;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = hit_r;
  assign out_ch.hit_addr        = hit_addr_r;
  assign out_ch.hit_dirty       = hit_dirty_r;
  assign out_ch.writeback       = wb_r;
  assign out_ch.writeback_addr  = wb_addr_r;
  assign out_ch.swap_count      = swap_tot_r;
  assign out_ch.writeback_count = wb_tot_r;

  always_comb begin
    age_seen = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (int'(ent_age_r[i]) < WAYS) begin
        age_seen[ent_age_r[i]] = 1'b1;
      end
    end
  end

  `ASSERT_RST(a_age_perm, &age_seen, "entry ages are not a permutation")
  `ASSERT_RST(a_exec_sets_valid, cmd.exec |=> out_valid_r, "result not presented after update")
  `ASSERT_RST(a_hit_wb_excl, out_valid_r |-> !(hit_r && wb_r), "hit and writeback together")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for victim_cache_lru_swap: random and directed requests against a
// scoreboard class that tracks entries, LRU ages and totals to predict every result.
// Depends on vcls_pkg, vcls_in_if, vcls_out_if and the victim cache RTL.
module tb_top;
  import vcls_pkg::*;

  localparam int NWAYS = 4;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 214;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] hit_addr;
    logic              hit_dirty;
    logic              writeback;
    logic [ADDR_W-1:0] writeback_addr;
    logic [CNT_W-1:0]  swap_count;
    logic [CNT_W-1:0]  writeback_count;
  } cache_result_t;

  class cache_scoreboard;
    logic [OFF_W-1:0]  offset;
    logic [ADDR_W-1:0] line_addr[NWAYS];
    bit                line_valid[NWAYS];
    bit                line_dirty[NWAYS];
    int unsigned       line_age[NWAYS];
    logic [CNT_W-1:0]  swaps;
    logic [CNT_W-1:0]  writebacks;
    cache_result_t     expected_q[$];
    int unsigned       mismatches;

    function new();
      offset = OFF_RESET;
      for (int i = 0; i < NWAYS; i++) begin
        line_addr[i]  = '0;
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_age[i]   = NWAYS - 1 - i;
      end
      swaps      = '0;
      writebacks = '0;
      mismatches = 0;
    endfunction

    function void set_offset(logic [OFF_W-1:0] value);
      offset = value;
    endfunction

    function void note_request(logic func, logic [ADDR_W-1:0] addr,
                               logic [ADDR_W-1:0] swap_addr, logic dirty);
      cache_result_t r;
      int victim;
      int unsigned oldest;
      int unsigned hit_age;
      bit found;
      r = '0;
      if (func == FUNC_INSERT) begin
        victim = 0;
        oldest = 0;
        for (int i = 0; i < NWAYS; i++) begin
          if (line_age[i] >= oldest) begin
            oldest = line_age[i];
            victim = i;
          end
        end
        for (int i = 0; i < NWAYS; i++) line_age[i]++;
        line_age[victim] = 0;
        if (line_dirty[victim]) begin
          r.writeback      = 1'b1;
          r.writeback_addr = line_addr[victim];
          writebacks++;
        end
        line_addr[victim]  = addr;
        line_valid[victim] = 1'b1;
        line_dirty[victim] = dirty;
      end else begin
        found = 1'b0;
        for (int i = 0; i < NWAYS && !found; i++) begin
          if (line_valid[i] && (line_addr[i] >> offset) == (addr >> offset)) begin
            found       = 1'b1;
            hit_age     = line_age[i];
            r.hit       = 1'b1;
            r.hit_addr  = line_addr[i];
            r.hit_dirty = line_dirty[i];
            swaps++;
            line_addr[i]  = swap_addr;
            line_dirty[i] = dirty;
            for (int k = 0; k < NWAYS; k++)
              if (line_age[k] < hit_age) line_age[k]++;
            line_age[i] = 0;
          end
        end
      end
      r.swap_count      = swaps;
      r.writeback_count = writebacks;
      expected_q.push_back(r);
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: hit=%0b hit_addr=%h wb=%0b wb_addr=%h",
                   got.hit, got.hit_addr, got.writeback, got.writeback_addr);
      end else begin
        exp = expected_q.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch exp: hit=%0b ha=%h hd=%0b wb=%0b wa=%h sw=%0d wbc=%0d",
                     exp.hit, exp.hit_addr, exp.hit_dirty, exp.writeback,
                     exp.writeback_addr, exp.swap_count, exp.writeback_count);
            $display("         got: hit=%0b ha=%h hd=%0b wb=%0b wa=%h sw=%0d wbc=%0d",
                     got.hit, got.hit_addr, got.hit_dirty, got.writeback,
                     got.writeback_addr, got.swap_count, got.writeback_count);
          end
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [OFF_W-1:0] cfg_wdata;
  bit               steady;
  bit               hold_request;
  logic [ADDR_W-1:0] recent_addr[8];

  cache_scoreboard sb = new();

  vcls_in_if  in_bus();
  vcls_out_if out_bus();

  victim_cache_lru_swap #(.WAYS(NWAYS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    cache_result_t r;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        sb.note_request(in_bus.func, in_bus.addr, in_bus.swap_addr, in_bus.dirty);
      if (out_bus.valid && out_bus.ready) begin
        r.hit             = out_bus.hit;
        r.hit_addr        = out_bus.hit_addr;
        r.hit_dirty       = out_bus.hit_dirty;
        r.writeback       = out_bus.writeback;
        r.writeback_addr  = out_bus.writeback_addr;
        r.swap_count      = out_bus.swap_count;
        r.writeback_count = out_bus.writeback_count;
        sb.check_result(r);
      end
    end
  end

  // The result sink stalls at random, and once for a long stretch on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 2);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic func, input logic [ADDR_W-1:0] addr,
                              input logic [ADDR_W-1:0] swap_addr, input logic dirty);
    in_bus.valid     <= 1'b1;
    in_bus.func      <= func;
    in_bus.addr      <= addr;
    in_bus.swap_addr <= swap_addr;
    in_bus.dirty     <= dirty;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic pause_sender();
    int n;
    if (!steady && $urandom_range(0, 2) == 0) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_offset(input logic [OFF_W-1:0] value);
    in_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_offset(value);
  endtask

  task automatic send_random_item();
    int unsigned       pick;
    logic [ADDR_W-1:0] low_mask;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] s;
    pick     = $urandom_range(0, 99);
    low_mask = (32'h1 << sb.offset) - 1;
    s = ($urandom_range(0, 3) == 0) ? recent_addr[$urandom_range(0, 7)] : $urandom;
    if (pick < 55) begin
      a = sb.line_addr[$urandom_range(0, NWAYS - 1)];
      a = (a & ~low_mask) | ($urandom & low_mask);
      if (pick >= 45) a = a ^ (32'h1 << $urandom_range(sb.offset, 31));
      send_request(FUNC_LOOKUP, a, s, $urandom_range(0, 1) == 1);
    end else if (pick < 65) begin
      a = $urandom;
      send_request(FUNC_LOOKUP, a, s, $urandom_range(0, 1) == 1);
    end else begin
      case ($urandom_range(0, 3))
        0, 1:    a = $urandom;
        2:       a = recent_addr[$urandom_range(0, 7)];
        default: a = sb.line_addr[$urandom_range(0, NWAYS - 1)];
      endcase
      send_request(FUNC_INSERT, a, s, $urandom_range(0, 1) == 1);
    end
    recent_addr[$urandom_range(0, 7)] = ($urandom_range(0, 1) == 1) ? a : s;
  endtask

  // Fills the cache, hits on duplicate tags and forces dirty evictions.
  task automatic run_directed();
    send_request(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_request(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(FUNC_INSERT, 32'h1234_5660, 32'h0000_0000, 1'b1);
    send_request(FUNC_INSERT, 32'h1234_5670, 32'h0000_0000, 1'b0);
    send_request(FUNC_LOOKUP, 32'h1234_567F, 32'hAAAA_AAA0, 1'b1);
    send_request(FUNC_LOOKUP, 32'hFFFF_FFE0, 32'h5555_5540, 1'b0);
    send_request(FUNC_LOOKUP, 32'h0000_001F, 32'h0000_0000, 1'b1);
    send_request(FUNC_LOOKUP, 32'h7777_7777, 32'hFFFF_FFFF, 1'b1);
    send_request(FUNC_INSERT, 32'hDEAD_BEE0, 32'h0000_0000, 1'b0);
    send_request(FUNC_INSERT, 32'h0BAD_F00D, 32'h0000_0000, 1'b1);
    send_request(FUNC_INSERT, 32'hCAFE_0000, 32'h0000_0000, 1'b1);
    send_request(FUNC_INSERT, 32'h8000_0000, 32'h0000_0000, 1'b1);
    send_request(FUNC_INSERT, 32'h4000_0020, 32'h0000_0000, 1'b0);
    send_request(FUNC_INSERT, 32'h4000_0020, 32'h0000_0000, 1'b1);
    send_request(FUNC_LOOKUP, 32'h4000_003F, 32'hFFFF_FFE0, 1'b1);
    send_request(FUNC_LOOKUP, 32'h4000_0020, 32'h0000_0001, 1'b0);
    send_request(FUNC_INSERT, 32'h0000_0001, 32'h0000_0000, 1'b1);
    send_request(FUNC_INSERT, 32'h0000_0002, 32'h0000_0000, 1'b1);
    send_request(FUNC_LOOKUP, 32'h8000_001F, 32'h1111_1111, 1'b0);
  endtask

  initial begin
    logic [OFF_W-1:0] offsets[7];
    offsets = '{4'd5, 4'd0, 4'd12, 4'd15, 4'd13, 4'd3, 4'd9};
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.func      <= FUNC_LOOKUP;
    in_bus.addr      <= '0;
    in_bus.swap_addr <= '0;
    in_bus.dirty     <= 1'b0;
    steady       = 1'b0;
    hold_request = 1'b0;
    foreach (recent_addr[i]) recent_addr[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 7; p++) begin
      write_offset(offsets[p]);
      if (p == 0) run_directed();
      steady = 1'b1;
      if (p == 2) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 30) steady = 1'b0;
        send_random_item();
        pause_sender();
      end
      steady = 1'b0;
    end
    in_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/vcls_pkg.sv
rtl/vcls_in_if.sv
rtl/vcls_out_if.sv
rtl/vcls_ctrl.sv
rtl/vcls_dp.sv
rtl/victim_cache_lru_swap.sv
dv/tb_top.sv
